>>> sv/ccm_pkg.sv
`timescale 1ns / 1ps

package ccm_pkg;

    localparam int CHAN_W        = 8;
    localparam int QUO_BITS      = 8;
    localparam int SUM_W         = 10;
    localparam int NUM_W         = 16;
    localparam int CMP_W         = NUM_W + 2;
    localparam int CHROMA_STAGES = QUO_BITS + 1;
    localparam int DIFF_STAGE    = CHROMA_STAGES;
    localparam int OUT_STAGE     = CHROMA_STAGES + 1;
    localparam int NUM_STAGES    = CHROMA_STAGES + 2;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    localparam logic [CHAN_W-1:0] CHAN_MAX            = 8'd255;
    localparam logic [CHAN_W-1:0] TARGET_BLUE_RESET   = 8'd0;
    localparam logic [CHAN_W-1:0] TARGET_GREEN_RESET  = 8'd0;
    localparam logic [CHAN_W-1:0] TARGET_RED_RESET    = 8'd255;
    localparam logic [CHAN_W-1:0] THRESHOLD_RESET     = 8'd220;

    typedef enum logic [1:0] {
        REG_TARGET_BLUE     = 2'd0,
        REG_TARGET_GREEN    = 2'd1,
        REG_TARGET_RED      = 2'd2,
        REG_MATCH_THRESHOLD = 2'd3
    } reg_index_t;

    // Normalized color as it leaves the divider pipeline.
    typedef struct packed {
        logic              zero;
        logic [CHAN_W-1:0] c0;
        logic [CHAN_W-1:0] c1;
    } chroma_t;

endpackage

>>> sv/chroma_color_key_mask.sv
// Throughput: one pixel per cycle while the m_ channel is not stalled; the eight
// bit-per-stage divider stages behind the sum stage set the depth, and every stage
// advances on its own when the next is free.
// Reset (aresetn low at a clock edge) empties the pipeline and returns the target
// color to pure red and the threshold to 220; there is no clearing pass.
`timescale 1ns / 1ps

module chroma_color_key_mask
    import ccm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CHAN_W-1:0]     s_pixel_blue,
    input  logic [CHAN_W-1:0]     s_pixel_green,
    input  logic [CHAN_W-1:0]     s_pixel_red,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAN_W-1:0]     m_chroma_distance,
    output logic                  m_selected
);

    logic [CHAN_W-1:0]     target_blue_reg;
    logic [CHAN_W-1:0]     target_green_reg;
    logic [CHAN_W-1:0]     target_red_reg;
    logic [CHAN_W-1:0]     threshold_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_en;
    reg_index_t            reg_index;
    logic                  cfg_write;
    chroma_t               pix_chroma;
    chroma_t               tgt_chroma;

    // Configuration registers.
    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_blue_reg  <= TARGET_BLUE_RESET;
            target_green_reg <= TARGET_GREEN_RESET;
            target_red_reg   <= TARGET_RED_RESET;
            threshold_reg    <= THRESHOLD_RESET;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_TARGET_BLUE:     target_blue_reg  <= pwdata[CHAN_W-1:0];
                REG_TARGET_GREEN:    target_green_reg <= pwdata[CHAN_W-1:0];
                REG_TARGET_RED:      target_red_reg   <= pwdata[CHAN_W-1:0];
                REG_MATCH_THRESHOLD: threshold_reg    <= pwdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_TARGET_BLUE:     prdata = {{(APB_DATA_W-CHAN_W){1'b0}}, target_blue_reg};
            REG_TARGET_GREEN:    prdata = {{(APB_DATA_W-CHAN_W){1'b0}}, target_green_reg};
            REG_TARGET_RED:      prdata = {{(APB_DATA_W-CHAN_W){1'b0}}, target_red_reg};
            REG_MATCH_THRESHOLD: prdata = {{(APB_DATA_W-CHAN_W){1'b0}}, threshold_reg};
            default:             prdata = '0;
        endcase
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        stage_en[OUT_STAGE] = !valid_reg[OUT_STAGE] || m_ready;
        for (int i = OUT_STAGE - 1; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_STAGES; i++) begin
            if (stage_en[i]) begin
                valid_next[i] = (i == 0) ? s_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[OUT_STAGE];

    // The target travels through its own divider in step with the pixel, so both
    // chroma values reach the distance stage together.
    ccm_chroma u_pix_chroma (
        .aclk     (aclk),
        .stage_en (stage_en[CHROMA_STAGES-1:0]),
        .in_blue  (s_pixel_blue),
        .in_green (s_pixel_green),
        .in_red   (s_pixel_red),
        .chroma   (pix_chroma)
    );

    ccm_chroma u_tgt_chroma (
        .aclk     (aclk),
        .stage_en (stage_en[CHROMA_STAGES-1:0]),
        .in_blue  (target_blue_reg),
        .in_green (target_green_reg),
        .in_red   (target_red_reg),
        .chroma   (tgt_chroma)
    );

    ccm_distance u_distance (
        .aclk      (aclk),
        .diff_en   (stage_en[DIFF_STAGE]),
        .out_en    (stage_en[OUT_STAGE]),
        .pix       (pix_chroma),
        .tgt       (tgt_chroma),
        .threshold (threshold_reg),
        .distance  (m_chroma_distance),
        .selected  (m_selected)
    );

endmodule

>>> sv/ccm_chroma.sv
`timescale 1ns / 1ps

module ccm_chroma
    import ccm_pkg::*;
(
    input  logic                     aclk,
    input  logic [CHROMA_STAGES-1:0] stage_en,
    input  logic [CHAN_W-1:0]        in_blue,
    input  logic [CHAN_W-1:0]        in_green,
    input  logic [CHAN_W-1:0]        in_red,
    output chroma_t                  chroma
);

    typedef struct packed {
        logic             q;
        logic [NUM_W-1:0] rem;
    } div_step_t;

    // One restoring division step: try to take sum << shift from the remainder.
    function automatic div_step_t div_step(input logic [NUM_W-1:0] rem,
                                           input logic [SUM_W-1:0] sum,
                                           input int unsigned shift);
        logic [CMP_W-1:0] divisor;
        div_step_t        r;
        divisor = {{(CMP_W-SUM_W){1'b0}}, sum} << shift;
        if ({2'b00, rem} >= divisor) begin
            r.q   = 1'b1;
            r.rem = rem - divisor[NUM_W-1:0];
        end else begin
            r.q   = 1'b0;
            r.rem = rem;
        end
        return r;
    endfunction

    function automatic logic [NUM_W-1:0] scale_chan(input logic [CHAN_W-1:0] v);
        return {v, {CHAN_W{1'b0}}} - {{(NUM_W-CHAN_W){1'b0}}, v};
    endfunction

    logic [SUM_W-1:0]  sum_reg   [QUO_BITS];
    logic [NUM_W-1:0]  rem_b_reg [QUO_BITS];
    logic [NUM_W-1:0]  rem_g_reg [QUO_BITS];
    logic [CHAN_W-1:0] q_b_reg   [CHROMA_STAGES];
    logic [CHAN_W-1:0] q_g_reg   [CHROMA_STAGES];
    logic              zero_reg  [CHROMA_STAGES];

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            sum_reg[0]   <= {2'b00, in_blue} + {2'b00, in_green} + {2'b00, in_red};
            rem_b_reg[0] <= scale_chan(in_blue);
            rem_g_reg[0] <= scale_chan(in_green);
            q_b_reg[0]   <= '0;
            q_g_reg[0]   <= '0;
            zero_reg[0]  <= ((in_blue | in_green | in_red) == '0);
        end
    end

    // Each stage settles one quotient bit, most significant first.
    for (genvar k = 1; k < CHROMA_STAGES; k++) begin : g_div
        div_step_t step_b;
        div_step_t step_g;

        always_comb begin
            step_b = div_step(rem_b_reg[k-1], sum_reg[k-1], QUO_BITS - k);
            step_g = div_step(rem_g_reg[k-1], sum_reg[k-1], QUO_BITS - k);
        end

        always_ff @(posedge aclk) begin
            if (stage_en[k]) begin
                q_b_reg[k]  <= {q_b_reg[k-1][CHAN_W-2:0], step_b.q};
                q_g_reg[k]  <= {q_g_reg[k-1][CHAN_W-2:0], step_g.q};
                zero_reg[k] <= zero_reg[k-1];
            end
        end

        if (k < QUO_BITS) begin : g_carry
            always_ff @(posedge aclk) begin
                if (stage_en[k]) begin
                    sum_reg[k]   <= sum_reg[k-1];
                    rem_b_reg[k] <= step_b.rem;
                    rem_g_reg[k] <= step_g.rem;
                end
            end
        end
    end

    // With a zero sum every trial step succeeds, so a black color is forced to zero here.
    assign chroma.zero = zero_reg[CHROMA_STAGES-1];
    assign chroma.c0   = zero_reg[CHROMA_STAGES-1] ? '0 : q_b_reg[CHROMA_STAGES-1];
    assign chroma.c1   = zero_reg[CHROMA_STAGES-1] ? '0 : q_g_reg[CHROMA_STAGES-1];

endmodule

>>> sv/ccm_distance.sv
`timescale 1ns / 1ps

module ccm_distance
    import ccm_pkg::*;
(
    input  logic              aclk,
    input  logic              diff_en,
    input  logic              out_en,
    input  chroma_t           pix,
    input  chroma_t           tgt,
    input  logic [CHAN_W-1:0] threshold,
    output logic [CHAN_W-1:0] distance,
    output logic              selected
);

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // A black color stays all zero; otherwise the third channel makes up the rest.
    function automatic logic [CHAN_W-1:0] third_chan(input chroma_t c);
        return c.zero ? '0 : (CHAN_MAX - c.c0 - c.c1);
    endfunction

    logic [CHAN_W-1:0] diff0_reg;
    logic [CHAN_W-1:0] diff1_reg;
    logic [CHAN_W-1:0] diff2_reg;
    logic [CHAN_W-1:0] dist_reg;
    logic              sel_reg;
    logic [SUM_W-1:0]  total;
    logic [CHAN_W-1:0] dist_next;

    always_ff @(posedge aclk) begin
        if (diff_en) begin
            diff0_reg <= abs_diff(pix.c0, tgt.c0);
            diff1_reg <= abs_diff(pix.c1, tgt.c1);
            diff2_reg <= abs_diff(third_chan(pix), third_chan(tgt));
        end
    end

    always_comb begin
        total     = {2'b00, diff0_reg} + {2'b00, diff1_reg} + {2'b00, diff2_reg};
        dist_next = (total > {2'b00, CHAN_MAX}) ? CHAN_MAX : total[CHAN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            dist_reg <= dist_next;
            sel_reg  <= (dist_next <= threshold);
        end
    end

    assign distance = dist_reg;
    assign selected = sel_reg;

endmodule

>>> sv/ccm_checker.sv
`timescale 1ns / 1ps

module ccm_checker
    import ccm_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [CHAN_W-1:0]     m_chroma_distance,
    input logic                  m_selected
);

    // A stalled result keeps its value until its transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chroma_distance) && $stable(m_selected))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present right after reset");

    // When the output side is free, every stage can move, so input is taken.
    a_ready_free: assert property (@(posedge aclk)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with a free output");

    // A register reads back what was just written to it.
    a_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(psel && penable && pwrite && pready) && $past(aresetn) && paddr == $past(paddr)
        |-> prdata == {{(APB_DATA_W-CHAN_W){1'b0}}, $past(pwdata[CHAN_W-1:0])})
        else $error("register readback mismatch");

endmodule

bind chroma_color_key_mask ccm_checker u_ccm_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ccm_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_PIXELS    = 190;
    localparam int MAX_REPORTS     = 30;

    typedef struct packed {
        logic [CHAN_W-1:0] distance;
        logic              selected;
    } key_result_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] threshold;
    } key_setting_t;

    logic                  aclk;
    logic                  aresetn           = 1'b0;
    logic                  psel              = 1'b0;
    logic                  penable           = 1'b0;
    logic                  pwrite            = 1'b0;
    logic [APB_ADDR_W-1:0] paddr             = '0;
    logic [APB_DATA_W-1:0] pwdata            = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid           = 1'b0;
    logic                  s_ready;
    logic [CHAN_W-1:0]     s_pixel_blue      = '0;
    logic [CHAN_W-1:0]     s_pixel_green     = '0;
    logic [CHAN_W-1:0]     s_pixel_red       = '0;
    logic                  m_valid;
    logic                  m_ready           = 1'b0;
    logic [CHAN_W-1:0]     m_chroma_distance;
    logic                  m_selected;

    key_setting_t key_setting;
    key_result_t  expected_keys[$];
    int           error_count     = 0;
    int           pixels_checked  = 0;
    int           pixels_selected = 0;
    int           settings_used   = 0;
    bit           sender_bursts   = 1'b0;
    bit           receiver_bursts = 1'b0;
    bit           hold_off_request = 1'b0;

    chroma_color_key_mask i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pixel_blue      (s_pixel_blue),
        .s_pixel_green     (s_pixel_green),
        .s_pixel_red       (s_pixel_red),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_chroma_distance (m_chroma_distance),
        .m_selected        (m_selected)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Chroma key prediction
    // ------------------------------------------------------------------

    // A black color has no chromaticity and stays at zero on all channels.
    function automatic void normalize_color(input int unsigned b, input int unsigned g,
                                            input int unsigned r, output int unsigned c0,
                                            output int unsigned c1, output int unsigned c2);
        int unsigned sum;
        sum = b + g + r;
        if (sum == 0) begin
            c0 = 0;
            c1 = 0;
            c2 = 0;
        end else begin
            c0 = (b * 255) / sum;
            c1 = (g * 255) / sum;
            c2 = 255 - c0 - c1;
        end
    endfunction

    function automatic int unsigned abs_delta(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic key_result_t predict_key(logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] g,
                                                logic [CHAN_W-1:0] r, key_setting_t setting);
        int unsigned pc0, pc1, pc2, tc0, tc1, tc2, key_dist;
        key_result_t result;
        normalize_color(32'(b), 32'(g), 32'(r), pc0, pc1, pc2);
        normalize_color(32'(setting.blue), 32'(setting.green), 32'(setting.red),
                        tc0, tc1, tc2);
        key_dist = abs_delta(pc0, tc0) + abs_delta(pc1, tc1) + abs_delta(pc2, tc2);
        if (key_dist > 255)
            key_dist = 255;
        result.distance = key_dist[CHAN_W-1:0];
        result.selected = (key_dist <= 32'(setting.threshold));
        return result;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("tb: MISMATCH at %0t ns: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin
        key_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_keys.size() == 0) begin
                report_mismatch($sformatf("unexpected result distance=%0d selected=%0b",
                                          m_chroma_distance, m_selected));
            end else begin
                want = expected_keys.pop_front();
                pixels_checked++;
                if (want.selected)
                    pixels_selected++;
                if (m_chroma_distance !== want.distance)
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                              m_chroma_distance, want.distance));
                if (m_selected !== want.selected)
                    report_mismatch($sformatf("selected %0b, expected %0b (distance %0d)",
                                              m_selected, want.selected, want.distance));
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_request = 1'b0;
            end else begin
                if (stall_left == 0 && receiver_bursts && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 17);
                if (stall_left > 0) begin
                    m_ready <= 1'b0;
                    stall_left--;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel and register traffic
    // ------------------------------------------------------------------

    // Called and returns at a falling edge; valid stays high for the next call.
    task automatic send_pixel(logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] g,
                              logic [CHAN_W-1:0] r);
        if (sender_bursts && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_blue  <= b;
        s_pixel_green <= g;
        s_pixel_red   <= r;
        do @(posedge aclk); while (!s_ready);
        expected_keys.push_back(predict_key(b, g, r, key_setting));
        @(negedge aclk);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (expected_keys.size() != 0)
            @(negedge aclk);
        repeat (NUM_STAGES) @(negedge aclk);
    endtask

    task automatic write_register(reg_index_t index, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(index) << 2;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            REG_TARGET_BLUE:     key_setting.blue      = data[CHAN_W-1:0];
            REG_TARGET_GREEN:    key_setting.green     = data[CHAN_W-1:0];
            REG_TARGET_RED:      key_setting.red       = data[CHAN_W-1:0];
            REG_MATCH_THRESHOLD: key_setting.threshold = data[CHAN_W-1:0];
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pwdata  <= '0;
        @(negedge aclk);
    endtask

    task automatic check_register(reg_index_t index);
        logic [CHAN_W-1:0] want;
        case (index)
            REG_TARGET_BLUE:     want = key_setting.blue;
            REG_TARGET_GREEN:    want = key_setting.green;
            REG_TARGET_RED:      want = key_setting.red;
            REG_MATCH_THRESHOLD: want = key_setting.threshold;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(index) << 2;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DATA_W'(want))
            report_mismatch($sformatf("register %s reads %0h, expected %0h",
                                      index.name(), prdata, want));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Upper data bits carry noise; only the low byte may land in a register.
    task automatic apply_setting(logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] g,
                                 logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] threshold);
        write_register(REG_TARGET_BLUE,     ($urandom() & 32'hFFFF_FF00) | b);
        write_register(REG_TARGET_GREEN,    ($urandom() & 32'hFFFF_FF00) | g);
        write_register(REG_TARGET_RED,      ($urandom() & 32'hFFFF_FF00) | r);
        write_register(REG_MATCH_THRESHOLD, ($urandom() & 32'hFFFF_FF00) | threshold);
        for (int i = 0; i < 4; i++)
            check_register(reg_index_t'(i));
        settings_used++;
    endtask

    function automatic logic [CHAN_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] near_level(logic [CHAN_W-1:0] level, int unsigned scale);
        int unsigned v;
        v = (32'(level) * scale) / 255 + $urandom_range(0, 6);
        return (v > 255) ? 8'd255 : v[CHAN_W-1:0];
    endfunction

    // Three in ten colors are scaled from the target so that matches are
    // frequent, the rest black, single-channel, very dark or fully random pixels.
    task automatic send_random_pixel();
        int unsigned scale;
        case ($urandom_range(0, 9))
            0: send_pixel(8'd0, 8'd0, 8'd0);
            1: begin
                case ($urandom_range(0, 2))
                    0: send_pixel(CHAN_W'($urandom_range(0, 255)), 8'd0, 8'd0);
                    1: send_pixel(8'd0, CHAN_W'($urandom_range(0, 255)), 8'd0);
                    default: send_pixel(8'd0, 8'd0, CHAN_W'($urandom_range(0, 255)));
                endcase
            end
            2, 3, 4: begin
                scale = $urandom_range(1, 255);
                send_pixel(near_level(key_setting.blue, scale),
                           near_level(key_setting.green, scale),
                           near_level(key_setting.red, scale));
            end
            5: send_pixel(CHAN_W'($urandom_range(0, 3)), CHAN_W'($urandom_range(0, 3)),
                          CHAN_W'($urandom_range(0, 3)));
            default: send_pixel(CHAN_W'($urandom_range(0, 255)),
                                CHAN_W'($urandom_range(0, 255)),
                                CHAN_W'($urandom_range(0, 255)));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reset_defaults();
        key_setting = '{TARGET_BLUE_RESET, TARGET_GREEN_RESET, TARGET_RED_RESET,
                        THRESHOLD_RESET};
        for (int i = 0; i < 4; i++)
            check_register(reg_index_t'(i));
        settings_used++;
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd128, 8'd64,  8'd32);
        send_pixel(8'd1,   8'd0,   8'd254);
        send_pixel(8'd170, 8'd85,  8'd0);
        wait_for_drain();
    endtask

    // A black target has no chroma; a white one sits at the center.
    task automatic test_black_and_white_targets();
        apply_setting(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);
        wait_for_drain();
        apply_setting(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd254);
        send_pixel(8'd0,   8'd255, 8'd255);
        wait_for_drain();
    endtask

    task automatic test_register_access();
        for (int i = 3; i >= 0; i--) begin
            write_register(reg_index_t'(i), 32'hFFFF_FFFF);
            check_register(reg_index_t'(i));
        end
        for (int i = 0; i < 4; i++) begin
            write_register(reg_index_t'(i), 32'hFFFF_FF00);
            check_register(reg_index_t'(i));
        end
    endtask

    task automatic test_random_colors();
        sender_bursts   = 1'b1;
        receiver_bursts = 1'b1;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: apply_setting(8'd0, 8'd0, 8'd0, 8'd255);
                1: apply_setting(8'd255, 8'd255, 8'd255, 8'd0);
                2: apply_setting(8'd255, 8'd0, 8'd0, CHAN_W'($urandom_range(0, 255)));
                default: apply_setting(pick_level(), pick_level(), pick_level(),
                                       pick_level());
            endcase
            for (int n = 0; n < PHASE_PIXELS; n++)
                send_random_pixel();
            wait_for_drain();
        end
    endtask

    // The output side holds off long enough for the pipeline to fill and
    // push back on the input while pixels keep being offered.
    task automatic test_output_backpressure();
        apply_setting(pick_level(), pick_level(), pick_level(),
                      CHAN_W'($urandom_range(60, 200)));
        sender_bursts   = 1'b0;
        receiver_bursts = 1'b0;
        hold_off_request = 1'b1;
        for (int n = 0; n < 60; n++)
            send_random_pixel();
        wait_for_drain();
    endtask

    task automatic test_full_rate();
        apply_setting(pick_level(), pick_level(), pick_level(), pick_level());
        sender_bursts   = 1'b0;
        receiver_bursts = 1'b0;
        for (int n = 0; n < 120; n++)
            send_random_pixel();
        wait_for_drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_black_and_white_targets();
        test_register_access();
        test_random_colors();
        test_output_backpressure();
        test_full_rate();
        $display("tb: compared %0d pixels over %0d key settings, %0d of them inside the key",
                 pixels_checked, settings_used, pixels_selected);
        $display("tb: covered black and white targets, bursty idling, a long output stall",
                 " and a full-rate stretch");
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> chroma_color_key_mask.f
sv/ccm_pkg.sv
sv/ccm_chroma.sv
sv/ccm_distance.sv
sv/chroma_color_key_mask.sv
sv/ccm_checker.sv
test/testbench.sv
